// File: design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

	localparam int VALUE_W = 32;
	localparam int RANK_W  = 31;
	localparam int OCC_W   = 5;

	// Value returned when a dequeue or peek finds the queue empty.
	localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	typedef enum logic [1:0] {
		MODE_ENQ  = 2'd0,
		MODE_DEQ  = 2'd1,
		MODE_PEEK = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// One stored entry of the queue.
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [RANK_W-1:0]         rank;
	} entry_t;

	// Operation broadcast to every cell of the chain.
	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/spq_cell.sv
// One cell of the sorted chain: holds an entry and trades it with its neighbors.
`default_nettype none

module spq_cell (
	input  wire logic                clk,
	input  wire spq_pkg::cell_ctrl_t ctrl,
	input  wire logic                occ,
	input  wire spq_pkg::entry_t     new_entry,
	input  wire spq_pkg::entry_t     left_entry,
	input  wire logic                left_take,
	input  wire spq_pkg::entry_t     right_entry,
	output logic                     take,
	output spq_pkg::entry_t          entry
);

	spq_pkg::entry_t entry_q;

	// The cell lies at or past the insertion point when it is empty or its rank
	// does not exceed the new rank; equal ranks move away from the top.
	assign take  = !occ || (entry_q.rank <= new_entry.rank);
	assign entry = entry_q;

	// Insert shifts away from the top; removal shifts toward it.
	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (take) begin
				entry_q <= left_take ? left_entry : new_entry;
			end
		end else if (ctrl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire

// File: design/sorted_priority_queue.sv
// Each operation gives its result word in the cycle after it is accepted.
// Throughput: one operation per cycle; every cell of the chain compares and shifts
// in parallel, so busy never rises.
// Reset clears the entry count and the result strobe; stored entries stay unknown
// until written, and there is no clearing pass.
// The receiver cannot stall: done is high for exactly one cycle per operation.
`default_nettype none

module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [1:0]                            mode,
	input  wire logic signed [spq_pkg::VALUE_W-1:0]    item_value,
	input  wire logic [spq_pkg::RANK_W-1:0]            item_rank,
	output logic                                       done,
	output logic signed [spq_pkg::VALUE_W-1:0]         out_value,
	output logic [1:0]                                 status,
	output logic [spq_pkg::OCC_W-1:0]                  occupancy
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]                        count_q;
	logic [CNT_W-1:0]                        count_d;
	logic                                    full;
	logic                                    empty;
	spq_pkg::cell_ctrl_t                     ctrl;
	spq_pkg::entry_t                         new_entry;
	spq_pkg::entry_t                         cell_entry [QUEUE_DEPTH];
	logic                                    cell_take  [QUEUE_DEPTH];

	logic                                    done_q;
	logic signed [spq_pkg::VALUE_W-1:0]      out_value_q;
	spq_pkg::status_t                        status_q;
	logic [spq_pkg::OCC_W-1:0]               occupancy_q;
	logic signed [spq_pkg::VALUE_W-1:0]      value_d;
	spq_pkg::status_t                        status_d;

	assign busy  = 1'b0;
	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	assign new_entry.value = item_value;
	assign new_entry.rank  = item_rank;

	// Decode the operation into the chain controls and the result word.
	always_comb begin
		ctrl     = '0;
		value_d  = '0;
		status_d = spq_pkg::ST_OK;
		count_d  = count_q;
		unique case (mode)
			spq_pkg::MODE_ENQ: begin
				if (full) begin
					status_d = spq_pkg::ST_FULL;
				end else begin
					ctrl.enq = start;
					count_d  = count_q + CNT_W'(1);
				end
			end
			spq_pkg::MODE_DEQ: begin
				if (empty) begin
					value_d  = spq_pkg::INT_MIN;
					status_d = spq_pkg::ST_EMPTY;
				end else begin
					ctrl.deq = start;
					value_d  = cell_entry[0].value;
					count_d  = count_q - CNT_W'(1);
				end
			end
			spq_pkg::MODE_PEEK: begin
				if (empty) begin
					value_d  = spq_pkg::INT_MIN;
					status_d = spq_pkg::ST_EMPTY;
				end else begin
					value_d = cell_entry[0].value;
				end
			end
			default: begin
				value_d = '0;
			end
		endcase
	end

	// Chain of cells, top of the queue in cell zero, ranks descending away from it.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		spq_pkg::entry_t left_entry;
		spq_pkg::entry_t right_entry;
		logic            left_take;
		logic            occ;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_entry = '0;
			assign left_take  = 1'b0;
		end else begin : g_inner_left
			assign left_entry = cell_entry[i-1];
			assign left_take  = cell_take[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_inner_right
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (occ),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.left_take   (left_take),
			.right_entry (right_entry),
			.take        (cell_take[i]),
			.entry       (cell_entry[i])
		);
	end

	// Entry count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= start;
			if (start) begin
				count_q <= count_d;
			end
		end
	end

	// Result word registers.
	always_ff @(posedge clk) begin
		if (start) begin
			out_value_q <= value_d;
			status_q    <= status_d;
			occupancy_q <= spq_pkg::OCC_W'(count_d);
		end
	end

	assign done      = done_q;
	assign out_value = out_value_q;
	assign status    = status_q;
	assign occupancy = occupancy_q;

	// Every accepted operation yields a result word in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> done) else $error("missing result word");

	// The count never exceeds the chain length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH)) else $error("entry count overflow");

	// An enqueue on a full queue is answered with a full status and keeps the count.
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		start && mode == spq_pkg::MODE_ENQ && full |=>
		done && status == spq_pkg::ST_FULL && count_q == $past(count_q))
		else $error("full enqueue not rejected");

	// An empty status always carries the minimum integer.
	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == spq_pkg::ST_EMPTY |-> out_value == spq_pkg::INT_MIN)
		else $error("empty result value wrong");

	// A successful dequeue lowers the count by one.
	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		start && mode == spq_pkg::MODE_DEQ && !empty |=>
		count_q == $past(count_q) - CNT_W'(1)) else $error("dequeue count wrong");

endmodule

`default_nettype wire

// File: sim/sorted_priority_queue_test.sv
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
`timescale 1ns / 100ps

module sorted_priority_queue_test;

	localparam int DEPTH    = 16;
	localparam int RAND_OPS = 1300;

	// One result word as it leaves the block.
	typedef struct packed {
		logic signed [spq_pkg::VALUE_W-1:0] value;
		spq_pkg::status_t                   status;
		logic [spq_pkg::OCC_W-1:0]          occ;
	} result_word_t;

	// One row of the directed table; fixed rows carry a hand-written result word.
	typedef struct packed {
		spq_pkg::mode_t                     op;
		logic signed [spq_pkg::VALUE_W-1:0] value;
		logic [spq_pkg::RANK_W-1:0]         rank;
		logic                               fixed;
		logic signed [spq_pkg::VALUE_W-1:0] want_value;
		spq_pkg::status_t                   want_status;
		logic [spq_pkg::OCC_W-1:0]          want_occ;
	} op_row_t;

	localparam op_row_t DIRECTED_OPS [0:23] = '{
		// Empty queue: peek and dequeue both report empty with the minimum integer.
		'{spq_pkg::MODE_PEEK, 32'sd0, 31'd0, 1'b1, spq_pkg::INT_MIN, spq_pkg::ST_EMPTY, 5'd0},
		'{spq_pkg::MODE_DEQ, 32'sd0, 31'd0, 1'b1, spq_pkg::INT_MIN, spq_pkg::ST_EMPTY, 5'd0},
		// Extreme values and ranks, then a tie on the highest rank.
		'{spq_pkg::MODE_ENQ, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 32'sd0, spq_pkg::ST_OK, 5'd1},
		'{spq_pkg::MODE_ENQ, spq_pkg::INT_MIN, 31'd0, 1'b1, 32'sd0, spq_pkg::ST_OK, 5'd2},
		'{spq_pkg::MODE_ENQ, -32'sd1, 31'h7FFF_FFFF, 1'b1, 32'sd0, spq_pkg::ST_OK, 5'd3},
		// The newer of two equal ranks sits on top.
		'{spq_pkg::MODE_PEEK, 32'sd0, 31'd0, 1'b1, -32'sd1, spq_pkg::ST_OK, 5'd3},
		'{spq_pkg::MODE_DEQ, 32'sd0, 31'd0, 1'b1, -32'sd1, spq_pkg::ST_OK, 5'd2},
		// Fill to the brim with mixed ranks and ties.
		'{spq_pkg::MODE_ENQ, 32'sd1, 31'd5, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_ENQ, 32'sd2, 31'd5, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_ENQ, 32'sd3, 31'd100, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_ENQ, 32'sh1234_5678, 31'd0, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_ENQ, -32'sd5, 31'h4000_0000, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_ENQ, 32'sd6, 31'd3, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_ENQ, 32'sd7, 31'd5, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_ENQ, 32'sh0F0F_0F0F, 31'd7, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_ENQ, -32'sd9, 31'h7FFF_FFFE, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_ENQ, 32'sd10, 31'd1, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_ENQ, 32'sd11, 31'd2, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_ENQ, 32'sh5A5A_5A5A, 31'd5, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_ENQ, 32'sd13, 31'd9, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_ENQ, -32'sd14, 31'h7FFF_FFFF, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		// A full queue turns the enqueue away and keeps its contents.
		'{spq_pkg::MODE_ENQ, 32'sh55AA_55AA, 31'd6, 1'b1, 32'sd0, spq_pkg::ST_FULL, 5'd16},
		'{spq_pkg::MODE_PEEK, 32'sd0, 31'd0, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0},
		'{spq_pkg::MODE_DEQ, 32'sd0, 31'd0, 1'b0, 32'sd0, spq_pkg::ST_OK, 5'd0}
	};

	logic                               clk;
	logic                               arst_n;
	logic                               start;
	logic                               busy;
	logic [1:0]                         mode;
	logic signed [spq_pkg::VALUE_W-1:0] item_value;
	logic [spq_pkg::RANK_W-1:0]         item_rank;
	logic                               done;
	logic signed [spq_pkg::VALUE_W-1:0] out_value;
	logic [1:0]                         status;
	logic [spq_pkg::OCC_W-1:0]          occupancy;

	// Shadow copy of the queue, kept sorted by ascending rank with the top entry last.
	spq_pkg::entry_t held [DEPTH];
	int              held_count;

	result_word_t pending_results [$];
	int           mismatches;
	int           ops_issued;
	int           words_checked;
	bit           idle_enabled;
	int           n_enq, n_deq, n_peek, n_full, n_empty, peak_count;

	sorted_priority_queue #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.item_value(item_value),
		.item_rank(item_rank),
		.done(done),
		.out_value(out_value),
		.status(status),
		.occupancy(occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog for a block that stops answering.
	initial begin
		#2_000_000;
		$display("Timeout: the block stopped producing result words");
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	// Apply one operation to the shadow queue and return the result word it should give.
	function automatic result_word_t apply_queue_op(input spq_pkg::mode_t op,
			input logic signed [spq_pkg::VALUE_W-1:0] value,
			input logic [spq_pkg::RANK_W-1:0] rank);
		result_word_t word;
		int           slot;
		word.value  = '0;
		word.status = spq_pkg::ST_OK;
		case (op)
			spq_pkg::MODE_ENQ: begin
				n_enq++;
				if (held_count >= DEPTH) begin
					word.status = spq_pkg::ST_FULL;
					n_full++;
				end else begin
					// Entries of strictly higher rank move up one place.
					slot = held_count;
					while (slot > 0 && held[slot-1].rank > rank) begin
						held[slot] = held[slot-1];
						slot--;
					end
					held[slot].value = value;
					held[slot].rank  = rank;
					held_count++;
					if (held_count > peak_count)
						peak_count = held_count;
				end
			end
			spq_pkg::MODE_DEQ: begin
				n_deq++;
				if (held_count == 0) begin
					word.value  = spq_pkg::INT_MIN;
					word.status = spq_pkg::ST_EMPTY;
					n_empty++;
				end else begin
					held_count--;
					word.value = held[held_count].value;
				end
			end
			spq_pkg::MODE_PEEK: begin
				n_peek++;
				if (held_count == 0) begin
					word.value  = spq_pkg::INT_MIN;
					word.status = spq_pkg::ST_EMPTY;
					n_empty++;
				end else begin
					word.value = held[held_count-1].value;
				end
			end
			default: ;
		endcase
		word.occ = held_count[spq_pkg::OCC_W-1:0];
		return word;
	endfunction

	// Present one operation, wait for it to be taken, and queue the word it should give.
	task automatic issue_op(input spq_pkg::mode_t op,
			input logic signed [spq_pkg::VALUE_W-1:0] value,
			input logic [spq_pkg::RANK_W-1:0] rank, input bit fixed,
			input result_word_t fixed_word);
		result_word_t want;
		while (idle_enabled && $urandom_range(99) < 6) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		mode       <= op;
		item_value <= value;
		item_rank  <= rank;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		want = apply_queue_op(op, value, rank);
		if (fixed)
			want = fixed_word;
		pending_results.insert(pending_results.size(), want);
		ops_issued++;
	endtask

	// Hold the sender off until every outstanding word has come back.
	task automatic drain_pending();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [spq_pkg::RANK_W-1:0] pick_rank();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return spq_pkg::RANK_W'($urandom_range(7));
			default: return spq_pkg::RANK_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [spq_pkg::VALUE_W-1:0] pick_value();
		case ($urandom_range(9))
			0:       return spq_pkg::INT_MIN;
			1:       return 32'sh7FFF_FFFF;
			2:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Compare each result word with the oldest expectation.
	always @(posedge clk) begin
		result_word_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result word with no operation outstanding");
			end else begin
				want = pending_results.pop_front();
				if (out_value !== want.value)
					report_mismatch($sformatf("out_value %0d, expected %0d",
						out_value, want.value));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, want.status));
				if (occupancy !== want.occ)
					report_mismatch($sformatf("occupancy %0d, expected %0d",
						occupancy, want.occ));
			end
			words_checked++;
		end
	end

	initial begin
		result_word_t   fixed_word;
		op_row_t        row;
		spq_pkg::mode_t op;
		int             burst_len;
		int             bias;
		int             pick;
		int             random_ops;
		bit             held_off;

		held_count   = 0;
		peak_count   = 0;
		mismatches   = 0;
		ops_issued   = 0;
		idle_enabled = 1'b1;
		held_off     = 1'b0;
		arst_n     <= 1'b0;
		start      <= 1'b0;
		mode       <= spq_pkg::MODE_ENQ;
		item_value <= '0;
		item_rank  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (DIRECTED_OPS[i]) begin
			row = DIRECTED_OPS[i];
			fixed_word.value  = row.want_value;
			fixed_word.status = row.want_status;
			fixed_word.occ    = row.want_occ;
			issue_op(row.op, row.value, row.rank, row.fixed, fixed_word);
		end

		// Random bursts, each leaning toward filling, draining or neither.
		fixed_word = '0;
		random_ops = 0;
		while (random_ops < RAND_OPS) begin
			burst_len = $urandom_range(60, 15);
			bias      = $urandom_range(2);
			if ((!held_off && random_ops >= 900) || $urandom_range(7) == 0) begin
				drain_pending();
				held_off = 1'b1;
			end
			for (int i = 0; i < burst_len; i++) begin
				// A long stretch runs back to back with no gaps.
				idle_enabled = !(random_ops >= 400 && random_ops < 700);
				pick = $urandom_range(99);
				case (bias)
					0: op = (pick < 70) ? spq_pkg::MODE_ENQ
						: (pick < 90) ? spq_pkg::MODE_DEQ : spq_pkg::MODE_PEEK;
					1: op = (pick < 25) ? spq_pkg::MODE_ENQ
						: (pick < 85) ? spq_pkg::MODE_DEQ : spq_pkg::MODE_PEEK;
					default: op = (pick < 45) ? spq_pkg::MODE_ENQ
						: (pick < 80) ? spq_pkg::MODE_DEQ : spq_pkg::MODE_PEEK;
				endcase
				issue_op(op, pick_value(), pick_rank(), 1'b0, fixed_word);
				random_ops++;
			end
		end

		// Let the last words come back, then check that none are still missing.
		start <= 1'b0;
		for (int n = 0; n < 200 && pending_results.size() != 0; n++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived",
				pending_results.size()));

		$display("Covered %0d operations: %0d enqueues (%0d turned away full),",
			ops_issued, n_enq, n_full);
		$display("%0d dequeues, %0d peeks, %0d empty reads, deepest fill %0d, %0d words checked",
			n_deq, n_peek, n_empty, peak_count, words_checked);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: sim.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
sim/sorted_priority_queue_test.sv
